[rtl/two_level_bitmap_id_allocator_defines.svh]
// Assertion helpers for the allocator RTL.
`ifndef TWO_LEVEL_BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define TWO_LEVEL_BITMAP_ID_ALLOCATOR_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TLBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TLBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tlba_pkg.sv]
package tlba_pkg;

   localparam int LEAF_COUNT = 64;
   localparam int LEAF_W     = 64;
   localparam int LEAF_AW    = 6;
   localparam int BIT_AW     = 6;
   localparam int ID_W       = 13;

   typedef enum logic [2:0] {
      MODE_ACQ_ANY   = 3'd0,
      MODE_ACQ_ID    = 3'd1,
      MODE_RELEASE   = 3'd2,
      MODE_QUERY     = 3'd3,
      MODE_CLEAR_ALL = 3'd4
   } mode_type;

   // Control from the sequencer to the leaf store.
   typedef struct packed {
      logic               rd_en;
      logic [LEAF_AW-1:0] rd_addr;
      logic               wr_en;
      logic [LEAF_AW-1:0] wr_addr;
      logic               clear;
   } mem_ctl_type;

   // Index of the lowest clear bit; the top bit is set when every bit is set.
   function automatic logic [BIT_AW:0] lowest_clear(input logic [LEAF_W-1:0] v);
      logic [BIT_AW:0] idx;
      idx = (BIT_AW+1)'(LEAF_W);
      for (int i = LEAF_W - 1; i >= 0; i--) begin
         if (!v[i]) begin
            idx = (BIT_AW+1)'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/tlba_leaf_mem.sv]
module tlba_leaf_mem #(
   parameter int MAX_ID = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tlba_pkg::mem_ctl_type           ctl,
   input  logic [tlba_pkg::LEAF_W-1:0]     wr_data,
   output logic [tlba_pkg::LEAF_W-1:0]     rd_data
);
   import tlba_pkg::*;

   localparam int FULL_LEAVES = MAX_ID / LEAF_W;
   localparam int PART_BITS   = MAX_ID % LEAF_W;
   localparam logic [LEAF_W-1:0] PartMask = ~((LEAF_W'(1) << PART_BITS) - LEAF_W'(1));

   // Word a leaf holds after reset: ids beyond MAX_ID read as taken.
   function automatic logic [LEAF_W-1:0] reset_word(input logic [LEAF_AW-1:0] w);
      logic [LEAF_W-1:0] word;
      if ({1'b0, w} < (LEAF_AW+1)'(FULL_LEAVES)) begin
         word = '0;
      end else if ({1'b0, w} == (LEAF_AW+1)'(FULL_LEAVES)) begin
         word = PartMask;
      end else begin
         word = '1;
      end
      return word;
   endfunction

   logic [LEAF_W-1:0]     mem [LEAF_COUNT];
   logic [LEAF_COUNT-1:0] vld_ff;
   logic [LEAF_W-1:0]     rd_word_ff;
   logic                  rd_vld_ff;
   logic [LEAF_AW-1:0]    rd_addr_ff;

   // Track which leaves were written since reset or the last clear.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         vld_ff <= '0;
      end else if (ctl.wr_en) begin
         vld_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
   end

   // Registered read port; hold the last read until the next one.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_word_ff <= mem[ctl.rd_addr];
         rd_vld_ff  <= vld_ff[ctl.rd_addr];
         rd_addr_ff <= ctl.rd_addr;
      end
   end

   // Substitute the reset word for a leaf never written.
   assign rd_data = rd_vld_ff ? rd_word_ff : reset_word(rd_addr_ff);

endmodule

[rtl/two_level_bitmap_id_allocator.sv]
// Two-level bitmap id allocator for ids 1..MAX_ID. In the cycle a request transfers,
// the target leaf word is read from the 64 x 64 leaf memory (for acquire_any the
// leaf is picked from the full-leaf summary register); in the ST_RMW state the word
// is modified, written back together with the summary, and the response is loaded
// into the output register. The single read-modify-write path on the leaf memory
// means no new request is taken until the current one is written back. A new
// request is taken while a response waits; its write-back holds until the response
// transfers. Reset and clear_all take effect at once through per-leaf valid bits,
// with no clearing pass.
`include "two_level_bitmap_id_allocator_defines.svh"

module two_level_bitmap_id_allocator #(
   parameter int MAX_ID = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_mode,
   input  logic [tlba_pkg::ID_W-1:0]   req_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tlba_pkg::ID_W-1:0]   rsp_result_id,
   output logic                        rsp_success,
   output logic                        rsp_in_use,
   output logic                        rsp_bad_id
);
   import tlba_pkg::*;

   localparam int USED_LEAVES = (MAX_ID + LEAF_W - 1) / LEAF_W;
   localparam logic [LEAF_COUNT-1:0] SumReset =
      ~((LEAF_COUNT'(1) << USED_LEAVES) - LEAF_COUNT'(1));
   localparam logic [ID_W-1:0] MaxIdC = ID_W'(MAX_ID);

   typedef enum logic {ST_IDLE, ST_RMW} state_type;

   state_type            state_ff;
   logic [2:0]           op_ff;
   logic [LEAF_AW-1:0]   leaf_ff;
   logic [BIT_AW-1:0]    bit_ff;
   logic                 idok_ff;
   logic                 found_ff;
   logic [LEAF_COUNT-1:0] sum_ff;
   logic                 rsp_valid_ff;
   logic [ID_W-1:0]      rsp_result_id_ff;
   logic                 rsp_success_ff;
   logic                 rsp_in_use_ff;
   logic                 rsp_bad_id_ff;

   logic                 accept;
   logic                 fire;
   logic                 id_ok;
   logic [ID_W-2:0]      id_m1;
   logic [BIT_AW:0]      sum_pick;
   logic [BIT_AW:0]      leaf_pick;
   mem_ctl_type          mem_ctl;
   logic [LEAF_W-1:0]    mem_rd_data;
   logic [LEAF_W-1:0]    mem_wr_data;
   logic [LEAF_COUNT-1:0] sum_in;
   logic [ID_W-1:0]      res_id_in;
   logic                 success_in;
   logic                 in_use_in;
   logic                 bad_id_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == ST_RMW) && (!rsp_valid_ff || rsp_ready);

   // Decode the request and pick the leaf to read.
   assign id_ok    = (req_id != '0) && (req_id <= MaxIdC);
   assign id_m1    = (ID_W-1)'(req_id - ID_W'(1));
   assign sum_pick = lowest_clear(sum_ff);

   tlba_leaf_mem #(
      .MAX_ID (MAX_ID)
   ) u_leaf_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   assign leaf_pick = lowest_clear(mem_rd_data);

   // Modify the leaf word and build the response.
   always_comb begin
      mem_ctl.rd_en   = accept;
      mem_ctl.rd_addr = (req_mode == MODE_ACQ_ANY) ? sum_pick[BIT_AW-1:0]
                                                   : id_m1[ID_W-2:BIT_AW];
      mem_ctl.wr_en   = 1'b0;
      mem_ctl.wr_addr = leaf_ff;
      mem_ctl.clear   = 1'b0;
      mem_wr_data     = mem_rd_data;
      sum_in          = sum_ff;
      res_id_in       = '0;
      success_in      = 1'b0;
      in_use_in       = 1'b0;
      bad_id_in       = 1'b0;
      case (op_ff)
         MODE_ACQ_ANY: begin
            if (found_ff && !leaf_pick[BIT_AW]) begin
               mem_wr_data   = mem_rd_data | (LEAF_W'(1) << leaf_pick[BIT_AW-1:0]);
               mem_ctl.wr_en = fire;
               res_id_in     = ID_W'({leaf_ff, leaf_pick[BIT_AW-1:0]}) + ID_W'(1);
               success_in    = 1'b1;
               if (&mem_wr_data) begin
                  sum_in = sum_ff | (LEAF_COUNT'(1) << leaf_ff);
               end
            end
         end
         MODE_ACQ_ID: begin
            if (!idok_ff) begin
               bad_id_in = 1'b1;
            end else if (!mem_rd_data[bit_ff]) begin
               mem_wr_data   = mem_rd_data | (LEAF_W'(1) << bit_ff);
               mem_ctl.wr_en = fire;
               success_in    = 1'b1;
               if (&mem_wr_data) begin
                  sum_in = sum_ff | (LEAF_COUNT'(1) << leaf_ff);
               end
            end
         end
         MODE_RELEASE: begin
            if (!idok_ff) begin
               bad_id_in = 1'b1;
            end else begin
               mem_wr_data   = mem_rd_data & ~(LEAF_W'(1) << bit_ff);
               mem_ctl.wr_en = fire;
               sum_in        = sum_ff & ~(LEAF_COUNT'(1) << leaf_ff);
               success_in    = 1'b1;
            end
         end
         MODE_QUERY: begin
            if (!idok_ff) begin
               bad_id_in = 1'b1;
            end else begin
               in_use_in  = mem_rd_data[bit_ff];
               success_in = 1'b1;
            end
         end
         MODE_CLEAR_ALL: begin
            mem_ctl.clear = fire;
            sum_in        = SumReset;
            success_in    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequence: capture the request, then write back and load the response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= SumReset;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RMW;
                  op_ff    <= req_mode;
                  leaf_ff  <= (req_mode == MODE_ACQ_ANY) ? sum_pick[BIT_AW-1:0]
                                                         : id_m1[ID_W-2:BIT_AW];
                  bit_ff   <= id_m1[BIT_AW-1:0];
                  idok_ff  <= id_ok;
                  found_ff <= !sum_pick[BIT_AW];
               end
            end
            ST_RMW: begin
               if (fire) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (fire) begin
            sum_ff           <= sum_in;
            rsp_valid_ff     <= 1'b1;
            rsp_result_id_ff <= res_id_in;
            rsp_success_ff   <= success_in;
            rsp_in_use_ff    <= in_use_in;
            rsp_bad_id_ff    <= bad_id_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_result_id_ff;
   assign rsp_success   = rsp_success_ff;
   assign rsp_in_use    = rsp_in_use_ff;
   assign rsp_bad_id    = rsp_bad_id_ff;

   `TLBA_ASSERT_NOW(a_success_not_bad, clock, reset, rsp_valid, !(rsp_success && rsp_bad_id), "response both succeeded and flagged a bad id")
   `TLBA_ASSERT_NOW(a_in_use_needs_success, clock, reset, rsp_valid && rsp_in_use, rsp_success && !rsp_bad_id, "in_use reported without a successful query")
   `TLBA_ASSERT_NOW(a_grant_in_range, clock, reset, rsp_valid && (rsp_result_id != '0), rsp_success && (rsp_result_id <= MaxIdC), "granted id out of range or without success")
   `TLBA_ASSERT_NEXT(a_read_then_rmw, clock, reset, req_valid && req_ready, state_ff == ST_RMW, "request transfer did not start a write-back cycle")

endmodule

[sim/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tlba_pkg::*;

   localparam int MAX_ID = 4096;
   // Mode codes the block does not decode
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   // Mirror of the id pool: leaf used-bits, full-leaf summary and the responses still owed
   class id_pool_tracker;
      typedef struct {
         bit [ID_W-1:0] result_id;
         bit            success;
         bit            in_use;
         bit            bad_id;
      } outcome_t;

      bit [LEAF_W-1:0]     used_bits [LEAF_COUNT];
      bit [LEAF_COUNT-1:0] full_leaves;
      outcome_t            due_responses [$];
      int                  errors;

      function new();
         errors = 0;
         empty_pool();
      endfunction

      // Free every id; ids past MAX_ID stay marked so they are never granted
      function void empty_pool();
         for (int w = 0; w < LEAF_COUNT; w++) begin
            used_bits[w] = '0;
            for (int b = 0; b < LEAF_W; b++) begin
               if (w * LEAF_W + b + 1 > MAX_ID) used_bits[w][b] = 1'b1;
            end
         end
         full_leaves = '0;
         for (int w = 0; w < LEAF_COUNT; w++) begin
            if (&used_bits[w]) full_leaves[w] = 1'b1;
         end
      endfunction

      // Position of the lowest zero bit, 64 when the word is all ones
      function int first_free(bit [63:0] v);
         for (int i = 0; i < 64; i++) begin
            if (!v[i]) return i;
         end
         return 64;
      endfunction

      function void claim(int leaf, int pos);
         used_bits[leaf][pos] = 1'b1;
         if (&used_bits[leaf]) full_leaves[leaf] = 1'b1;
      endfunction

      // Update the pool for one transferred request and queue its response
      function void apply_request(logic [2:0] mode, logic [ID_W-1:0] id);
         outcome_t o;
         bit       ok;
         int       leaf, pos, l, b;
         o = '{default: 0};
         ok = (id != 0) && (int'(id) <= MAX_ID);
         leaf = ok ? (int'(id) - 1) / LEAF_W : 0;
         pos = ok ? (int'(id) - 1) % LEAF_W : 0;
         case (mode)
            MODE_ACQ_ANY: begin
               l = first_free(full_leaves);
               if (l < LEAF_COUNT) begin
                  b = first_free(used_bits[l]);
                  if (b < LEAF_W) begin
                     claim(l, b);
                     o.result_id = ID_W'(l * LEAF_W + b + 1);
                     o.success = 1'b1;
                  end
               end
            end
            MODE_ACQ_ID: begin
               if (!ok) o.bad_id = 1'b1;
               else if (!used_bits[leaf][pos]) begin
                  claim(leaf, pos);
                  o.success = 1'b1;
               end
            end
            MODE_RELEASE: begin
               if (!ok) o.bad_id = 1'b1;
               else begin
                  full_leaves[leaf] = 1'b0;
                  used_bits[leaf][pos] = 1'b0;
                  o.success = 1'b1;
               end
            end
            MODE_QUERY: begin
               if (!ok) o.bad_id = 1'b1;
               else begin
                  o.in_use = used_bits[leaf][pos];
                  o.success = 1'b1;
               end
            end
            MODE_CLEAR_ALL: begin
               empty_pool();
               o.success = 1'b1;
            end
            default: ;
         endcase
         due_responses.push_back(o);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Match one transferred response against the oldest owed one
      function void check_response(logic [ID_W-1:0] result_id, logic success,
                                   logic in_use, logic bad_id);
         outcome_t o;
         if (due_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual result_id %0d",
                     $time, result_id);
            errors++;
         end else begin
            o = due_responses.pop_front();
            compare_field("result_id", o.result_id, result_id);
            compare_field("success", o.success, success);
            compare_field("in_use", o.in_use, in_use);
            compare_field("bad_id", o.bad_id, bad_id);
         end
      endfunction

      // Some id currently in use, or a random valid id when the pool is empty
      function logic [ID_W-1:0] taken_id();
         int start, cand;
         start = $urandom_range(1, MAX_ID);
         for (int k = 0; k < MAX_ID; k++) begin
            cand = (start - 1 + k) % MAX_ID + 1;
            if (used_bits[(cand - 1) / LEAF_W][(cand - 1) % LEAF_W]) return ID_W'(cand);
         end
         return ID_W'(start);
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [2:0]      req_mode;
   logic [ID_W-1:0] req_id;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [ID_W-1:0] rsp_result_id;
   logic            rsp_success;
   logic            rsp_in_use;
   logic            rsp_bad_id;

   id_pool_tracker pool;
   bit             idle_on;
   int             idle_pct;

   two_level_bitmap_id_allocator #(
      .MAX_ID(MAX_ID)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_id(req_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_id(rsp_result_id),
      .rsp_success(rsp_success),
      .rsp_in_use(rsp_in_use),
      .rsp_bad_id(rsp_bad_id)
   );

   always #5ns clock = ~clock;

   function automatic logic [ID_W-1:0] valid_id();
      return ID_W'($urandom_range(1, MAX_ID));
   endfunction

   function automatic logic [ID_W-1:0] any_id();
      return ID_W'($urandom_range(0, (1 << ID_W) - 1));
   endfunction

   // Zero or something past MAX_ID
   function automatic logic [ID_W-1:0] bad_id_value();
      if ($urandom_range(0, 1)) return '0;
      return ID_W'($urandom_range(MAX_ID + 1, (1 << ID_W) - 1));
   endfunction

   // Present one request, hold it until it transfers, then maybe go quiet for a burst
   task automatic send(logic [2:0] mode, logic [ID_W-1:0] id);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_id <= id;
      do @(posedge clock); while (!req_ready);
      pool.apply_request(mode, id);
      if (idle_on && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Mostly acquire/release/query traffic on valid ids, some bad ids, spare modes and rare clears
   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 999);
      if (pick < 3) send(MODE_CLEAR_ALL, any_id());
      else if (pick < 400) send(MODE_ACQ_ANY, any_id());
      else if (pick < 520)
         send(MODE_ACQ_ID, ($urandom_range(0, 3) == 0) ? pool.taken_id() : valid_id());
      else if (pick < 680)
         send(MODE_RELEASE, ($urandom_range(0, 9) < 7) ? pool.taken_id() : valid_id());
      else if (pick < 880)
         send(MODE_QUERY, $urandom_range(0, 1) ? pool.taken_id() : valid_id());
      else if (pick < 960)
         send(mode_type'($urandom_range(MODE_ACQ_ID, MODE_QUERY)), bad_id_value());
      else send(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), any_id());
   endtask

   // Response side: check each transfer, stall in random bursts
   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            pool.check_response(rsp_result_id, rsp_success, rsp_in_use, rsp_bad_id);
         if (stall > 0) stall--;
         else if (idle_on && $urandom_range(0, 99) < idle_pct) stall = $urandom_range(1, 11);
         rsp_ready <= (stall == 0);
      end
   end

   initial begin : stimulus
      pool = new();
      idle_on = 1'b1;
      idle_pct = 25;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_ACQ_ANY;
      req_id <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: edge ids, taken and free ids, bad ids, spare modes, clear
      send(MODE_ACQ_ANY, '0);
      send(MODE_ACQ_ANY, '1);
      send(MODE_ACQ_ID, ID_W'(MAX_ID));
      send(MODE_ACQ_ID, ID_W'(MAX_ID));
      send(MODE_QUERY, ID_W'(MAX_ID));
      send(MODE_QUERY, ID_W'(1));
      send(MODE_QUERY, ID_W'(3));
      send(MODE_RELEASE, ID_W'(MAX_ID));
      send(MODE_RELEASE, ID_W'(MAX_ID));
      send(MODE_QUERY, ID_W'(MAX_ID));
      send(MODE_ACQ_ID, '0);
      send(MODE_RELEASE, '0);
      send(MODE_QUERY, '0);
      send(MODE_ACQ_ID, ID_W'(MAX_ID + 1));
      send(MODE_QUERY, '1);
      send(MODE_RELEASE, ID_W'(MAX_ID + 1));
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) send(3'(m), ID_W'(1));
      send(MODE_CLEAR_ALL, '1);
      send(MODE_QUERY, ID_W'(1));
      send(MODE_ACQ_ANY, '1);
      send(MODE_ACQ_ID, ID_W'(1));

      // Random traffic; every third segment runs without idling
      for (int seg = 0; seg < 7; seg++) begin
         idle_pct = (seg % 3 == 1) ? 0 : 30;
         for (int n = 0; n < 135; n++) random_request();
      end

      // Fill the lowest leaf back to back, then probe the summary around it
      idle_on = 1'b0;
      send(MODE_CLEAR_ALL, any_id());
      repeat (LEAF_W) send(MODE_ACQ_ANY, any_id());
      send(MODE_ACQ_ANY, any_id());
      send(MODE_ACQ_ID, ID_W'(1));
      send(MODE_QUERY, ID_W'(LEAF_W));
      send(MODE_RELEASE, ID_W'(LEAF_W / 2));
      send(MODE_ACQ_ANY, any_id());
      send(MODE_ACQ_ANY, any_id());
      send(MODE_RELEASE, ID_W'(LEAF_W));
      send(MODE_QUERY, ID_W'(LEAF_W));
      send(MODE_ACQ_ANY, any_id());
      req_valid <= 1'b0;

      // Drain owed responses, then watch a little longer for strays
      while (pool.due_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pool.errors == 0) begin
         $display("two_level_bitmap_id_allocator: match");
      end else begin
         $display("two_level_bitmap_id_allocator: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("two_level_bitmap_id_allocator: mismatch");
      $finish;
   end

endmodule

[two_level_bitmap_id_allocator.f]
+incdir+rtl
rtl/tlba_pkg.sv
rtl/tlba_leaf_mem.sv
rtl/two_level_bitmap_id_allocator.sv
sim/testbench.sv
